### src/ffc_pkg.sv
// Package: shared constants and types for the float/fixed converter.
package ffc_pkg;

	localparam int FRACTION_BITS_DEF = 8;

	typedef enum logic [1:0] {
		OP_INT2FIX = 2'd0,
		OP_FLT2FIX = 2'd1,
		OP_FIX2FLT = 2'd2,
		OP_FIX2INT = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_OVF     = 2'd1,
		ST_INVALID = 2'd2
	} status_t;

	typedef struct packed {
		logic [31:0] bits;
		status_t     st;
	} conv_res_t;

endpackage

### src/ffc_to_fixed.sv
// Conversions into fixed point: from int32 (wrap) and from float32 (round, saturate).
module ffc_to_fixed #(
	parameter int FRACTION_BITS = ffc_pkg::FRACTION_BITS_DEF
) (
	input  logic               is_float,
	input  logic [31:0]        operand,
	output ffc_pkg::conv_res_t res
);
	import ffc_pkg::*;

	localparam logic signed [33:0] LO = -(34'sd1 <<< (31 - FRACTION_BITS));
	localparam logic signed [33:0] HI = (34'sd1 <<< (31 - FRACTION_BITS)) - 34'sd1;
	localparam logic [8:0] SH0 = 9'(150 - FRACTION_BITS);

	logic signed [33:0] iv;
	logic        neg, sat, inf_nan;
	logic [7:0]  e;
	logic [23:0] m;
	logic [8:0]  eeff;
	logic [8:0]  shl, shr;
	logic [56:0] up;
	logic [33:0] mag;
	logic [25:0] rnd;
	logic [31:0] fbits;
	status_t     fst;

	always_comb begin
		iv = 34'(signed'(operand));
		neg = operand[31];
		e = operand[30:23];
		inf_nan = (e == 8'hFF);
		m = {(e != 8'd0), operand[22:0]};
		eeff = (e == 8'd0) ? 9'd1 : {1'b0, e};
		shl = eeff - SH0;
		shr = SH0 - eeff;
		up = '0;
		rnd = '0;
		mag = '0;
		sat = 1'b0;
		if (eeff >= SH0) begin
			if (shl > 9'd31) begin
				sat = (m != '0);
			end else begin
				up = 57'(m) << shl[4:0];
				mag = up[33:0];
				// Saturate when the scaled magnitude spills past the kept bits.
				if (up[56:34] != '0)
					sat = 1'b1;
			end
		end else if (shr <= 9'd25) begin
			rnd = 26'(m) + (26'd1 << (shr - 9'd1));
			mag = 34'(rnd >> shr);
		end
		if (inf_nan)
			sat = 1'b1;
		if (!neg && mag > 34'h07FFFFFFF)
			sat = 1'b1;
		if (neg && mag > 34'h080000000)
			sat = 1'b1;
		if (inf_nan && operand[22:0] != '0) begin
			fbits = '0;
			fst = ST_INVALID;
		end else if (sat) begin
			fbits = neg ? 32'h80000000 : 32'h7FFFFFFF;
			fst = ST_OVF;
		end else begin
			fbits = neg ? (32'd0 - mag[31:0]) : mag[31:0];
			fst = ST_OK;
		end
		if (is_float) begin
			res.bits = fbits;
			res.st = fst;
		end else begin
			res.bits = operand << FRACTION_BITS;
			res.st = (iv < LO || iv > HI) ? ST_OVF : ST_OK;
		end
	end
endmodule

### src/ffc_from_fixed.sv
// Conversions out of fixed point: to float32 (round to nearest even) and to int32 (floor).
module ffc_from_fixed #(
	parameter int FRACTION_BITS = ffc_pkg::FRACTION_BITS_DEF
) (
	input  logic               to_float,
	input  logic [31:0]        operand,
	output ffc_pkg::conv_res_t res
);
	import ffc_pkg::*;

	localparam logic [7:0] BIAS = 8'(127 - FRACTION_BITS);

	logic [31:0] mag, norm, fbits;
	logic [4:0]  p, lz;
	logic [24:0] mant;
	logic        g, stk;
	logic [7:0]  expo;

	always_comb begin
		mag = operand[31] ? (32'd0 - operand) : operand;
		lz = '0;
		for (int i = 0; i < 32; i++)
			if (mag[i])
				lz = 5'(31 - i);
		p = 5'd31 - lz;
		norm = mag << lz;
		g = norm[7];
		stk = (norm[6:0] != '0);
		mant = {1'b0, norm[31:8]};
		if (g && (stk || norm[8]))
			mant = mant + 25'd1;
		expo = {3'b0, p} + BIAS;
		if (mant[24]) begin
			mant = mant >> 1;
			expo = expo + 8'd1;
		end
		fbits = (mag == '0) ? '0 : {operand[31], expo, mant[22:0]};
		res.bits = to_float ? fbits : 32'($signed(operand) >>> FRACTION_BITS);
		res.st = ST_OK;
	end
endmodule

### src/float_fixed_point_converter.sv
// Top level: float/fixed/int converter with input and result registers.
//
//  channel | signals                                     | accepted when
//  in      | in_valid, in_ready, operation, operand      | in_valid && in_ready
//  out     | out_valid, out_ready, result_bits, status   | out_valid && out_ready
//
// One beat enters per cycle unless the output stalls; its result is registered in stage 2.
// The critical path is the float rounding adder or the leading-one search.
// Reset clears both valid flags; payload registers are not reset.
// A stalled output holds; the input register loads only when it is empty or when stage 2 frees.
module float_fixed_point_converter #(
	parameter int FRACTION_BITS = ffc_pkg::FRACTION_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [31:0] operand,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] result_bits,
	output logic [1:0]  status
);
	import ffc_pkg::*;

	logic        v_s1, v_s2, adv2;
	op_t         op_s1;
	logic [31:0] opnd_s1;
	conv_res_t   to_res, from_res, res_s2;

	assign adv2 = v_s1 && (!v_s2 || out_ready);
	assign in_ready = !v_s1 || adv2;

	// Hold the accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1 <= op_t'(operation);
			opnd_s1 <= operand;
		end
	end

	ffc_to_fixed #(.FRACTION_BITS(FRACTION_BITS)) u_to (
		.is_float(op_s1 == OP_FLT2FIX), .operand(opnd_s1), .res(to_res));
	ffc_from_fixed #(.FRACTION_BITS(FRACTION_BITS)) u_from (
		.to_float(op_s1 == OP_FIX2FLT), .operand(opnd_s1), .res(from_res));

	// Advance the result register when empty or drained.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (!v_s2 || out_ready) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2)
			res_s2 <= (op_s1 == OP_INT2FIX || op_s1 == OP_FLT2FIX) ? to_res : from_res;
	end

	assign out_valid = v_s2;
	assign result_bits = res_s2.bits;
	assign status = res_s2.st;
endmodule

### src/ffc_checker.sv
// Checker: port-level properties of the converter, bound to the top level.
module ffc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  operation,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] result_bits,
	input logic [1:0]  status
);
	import ffc_pkg::*;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_bits) && $stable(status))
		else $error("result changed while stalled");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("bad status code");
	a_ready_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##2 out_valid)
		else $error("result missing");
endmodule

bind float_fixed_point_converter ffc_checker u_ffc_checker (.*);
